// ===== hdl/vss_pkg.sv =====
// Package for the valve stage sequencer: field widths, command and register codes,
// configuration and status structs shared by the sequencer, statistics and top level.
// No dependencies.
`default_nettype none

package vss_pkg;

    localparam int MAX_STAGES   = 6;
    localparam int STAGE_W      = 3;
    localparam int DUR_W        = 16;
    localparam int VALVE_W      = 8;
    localparam int WORD_W       = 24;
    localparam int CYCLE_W      = 32;
    localparam int OXY_IN_W     = 10;
    localparam int STAT_W       = 14;
    localparam int SUM_W        = 32;
    localparam int CNT_W        = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int IN_DATA_W    = 24;
    localparam int OUT_DATA_W   = 184;

    localparam logic [STAT_W-1:0] STAT_MIN_START = STAT_W'(9999);
    localparam logic [STAT_W-1:0] FLOW_LIMIT     = STAT_W'(9999);

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_START  = 2'd2,
        CMD_STOP   = 2'd3
    } t_cmd;

    localparam logic [CFG_IDX_W-1:0] CFG_STAGE_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_VALVE_MASK  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_STAGE0      = CFG_IDX_W'(2);

    typedef struct packed {
        logic [STAGE_W-1:0]                   num_stages;
        logic [VALVE_W-1:0]                   valve_mask;
        logic [MAX_STAGES-1:0][WORD_W-1:0]    stage_word;
    } t_cfg;

    // Sequencer state as it stands after the current beat.
    typedef struct packed {
        logic [VALVE_W-1:0] valves;
        logic [STAGE_W-1:0] stage;
        logic [CYCLE_W-1:0] cycles;
    } t_seq_view;

    typedef struct packed {
        logic clear;
        logic fold;
        logic report;
    } t_stat_ctl;

    typedef struct packed {
        logic [STAT_W-1:0] oxy_lo;
        logic [STAT_W-1:0] oxy_hi;
        logic [SUM_W-1:0]  oxy_sum;
        logic [STAT_W-1:0] flow_lo;
        logic [STAT_W-1:0] flow_hi;
        logic [SUM_W-1:0]  flow_sum;
        logic [CNT_W-1:0]  count;
    } t_stats;

endpackage

`default_nettype wire

// ===== hdl/vss_seq.sv =====
// Stage sequencer: run flag, stage pointer, millisecond countdown, cycle counter,
// valve pattern register. Depends on vss_pkg.
`default_nettype none

module vss_seq
    import vss_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_fire,
    input  wire t_cmd      i_cmd,
    input  wire t_cfg      i_cfg,
    output t_seq_view      o_view,
    output t_stat_ctl      o_ctl
);

    logic               r_running,  n_running;
    logic [STAGE_W-1:0] r_stage,    n_stage;
    logic [DUR_W-1:0]   r_ticks,    n_ticks;
    logic [CYCLE_W-1:0] r_cycles,   n_cycles;
    logic               r_ended,    n_ended;
    logic [VALVE_W-1:0] r_valves,   n_valves;

    logic [WORD_W-1:0]  cur_word;
    logic [DUR_W-1:0]   cur_dur;
    logic [DUR_W-1:0]   dur0;
    logic [DUR_W-1:0]   ticks_dec;
    logic [STAGE_W:0]   stage_inc;
    logic [STAGE_W:0]   eff_count;

    always_comb begin
        cur_word = '0;
        if (r_stage < STAGE_W'(MAX_STAGES)) begin
            cur_word = i_cfg.stage_word[r_stage];
        end
        cur_dur = (cur_word[WORD_W-1:VALVE_W] == '0) ? DUR_W'(1) : cur_word[WORD_W-1:VALVE_W];
        dur0    = (i_cfg.stage_word[0][WORD_W-1:VALVE_W] == '0)
                ? DUR_W'(1) : i_cfg.stage_word[0][WORD_W-1:VALVE_W];
        // Clamp the stage count into 1..MAX_STAGES.
        if (i_cfg.num_stages == '0) begin
            eff_count = (STAGE_W+1)'(1);
        end else if ({1'b0, i_cfg.num_stages} > (STAGE_W+1)'(MAX_STAGES)) begin
            eff_count = (STAGE_W+1)'(MAX_STAGES);
        end else begin
            eff_count = {1'b0, i_cfg.num_stages};
        end
        ticks_dec = (r_ticks != '0) ? r_ticks - DUR_W'(1) : '0;
        stage_inc = {1'b0, r_stage} + (STAGE_W+1)'(1);
    end

    always_comb begin
        n_running = r_running;
        n_stage   = r_stage;
        n_ticks   = r_ticks;
        n_cycles  = r_cycles;
        n_ended   = r_ended;
        n_valves  = r_valves;
        o_ctl     = '0;
        if (i_fire) begin
            unique case (i_cmd)
                CMD_START: begin
                    n_stage   = '0;
                    n_cycles  = '0;
                    n_ended   = 1'b0;
                    n_ticks   = dur0;
                    n_running = 1'b1;
                    o_ctl.clear = 1'b1;
                end
                CMD_STOP: begin
                    n_running = 1'b0;
                end
                CMD_TICK: begin
                    if (r_running) begin
                        n_ticks = ticks_dec;
                        if (ticks_dec == '0) begin
                            n_valves = (r_valves & ~i_cfg.valve_mask)
                                     | (cur_word[VALVE_W-1:0] & i_cfg.valve_mask);
                            n_ticks  = cur_dur;
                            if (stage_inc >= eff_count) begin
                                n_stage  = '0;
                                n_cycles = r_cycles + CYCLE_W'(1);
                                n_ended  = 1'b1;
                            end else begin
                                n_stage = stage_inc[STAGE_W-1:0];
                            end
                        end
                    end
                end
                CMD_SAMPLE: begin
                    if (r_running) begin
                        o_ctl.fold   = 1'b1;
                        o_ctl.report = r_ended;
                        n_ended      = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_stage   <= '0;
            r_ticks   <= '0;
            r_cycles  <= '0;
            r_ended   <= 1'b0;
            r_valves  <= '0;
        end else begin
            r_running <= n_running;
            r_stage   <= n_stage;
            r_ticks   <= n_ticks;
            r_cycles  <= n_cycles;
            r_ended   <= n_ended;
            r_valves  <= n_valves;
        end
    end

    // Packed order: valves, stage, cycles.
    assign o_view = {n_valves, n_stage, n_cycles};

endmodule

`default_nettype wire

// ===== hdl/vss_stats.sv =====
// Per-cycle sensor statistics: min, max, saturating sums and sample count.
// Reports the finished cycle's values before folding in a new sample. Depends on vss_pkg.
`default_nettype none

module vss_stats
    import vss_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_stat_ctl             i_ctl,
    input  wire logic [OXY_IN_W-1:0]   i_oxygen,
    input  wire logic [STAT_W-1:0]     i_flow,
    output t_stats                     o_stats
);

    t_stats            r_acc, n_acc;
    t_stats            base;
    logic [STAT_W-1:0] oxy;
    logic [STAT_W-1:0] flow;
    logic [SUM_W:0]    oxy_add;
    logic [SUM_W:0]    flow_add;

    localparam t_stats CLEARED = '{
        oxy_lo:  STAT_MIN_START, oxy_hi:  '0, oxy_sum:  '0,
        flow_lo: STAT_MIN_START, flow_hi: '0, flow_sum: '0,
        count:   '0
    };

    always_comb begin
        oxy      = STAT_W'(i_oxygen);
        flow     = (i_flow > FLOW_LIMIT) ? FLOW_LIMIT : i_flow;
        base     = i_ctl.report ? CLEARED : r_acc;
        oxy_add  = {1'b0, base.oxy_sum}  + (SUM_W+1)'(oxy);
        flow_add = {1'b0, base.flow_sum} + (SUM_W+1)'(flow);
        n_acc    = r_acc;
        if (i_ctl.clear) begin
            n_acc = CLEARED;
        end else if (i_ctl.fold) begin
            n_acc.oxy_lo   = (oxy < base.oxy_lo)   ? oxy  : base.oxy_lo;
            n_acc.oxy_hi   = (oxy > base.oxy_hi)   ? oxy  : base.oxy_hi;
            n_acc.oxy_sum  = oxy_add[SUM_W]  ? '1 : oxy_add[SUM_W-1:0];
            n_acc.flow_lo  = (flow < base.flow_lo) ? flow : base.flow_lo;
            n_acc.flow_hi  = (flow > base.flow_hi) ? flow : base.flow_hi;
            n_acc.flow_sum = flow_add[SUM_W] ? '1 : flow_add[SUM_W-1:0];
            n_acc.count    = (base.count == '1) ? base.count : base.count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= CLEARED;
        end else begin
            r_acc <= n_acc;
        end
    end

    // Report the finished cycle; zeros when no report is due.
    assign o_stats = i_ctl.report ? r_acc : '0;

endmodule

`default_nettype wire

// ===== hdl/valve_stage_sequencer_with_stats.sv =====
// Top level of the valve stage sequencer with per-cycle statistics: configuration
// registers, command stream in, one result beat out per command. Uses vss_pkg,
// vss_seq and vss_stats.
`default_nettype none

// Each accepted command beat (tick, sample, start, stop) produces exactly one result
// beat. The whole update is combinational logic from the accepted beat into the state
// registers and the output register, so the block takes one beat per clock: o_s_tready
// is high whenever the output register is empty or is being drained in the same cycle,
// and a result appears on the master side the cycle after its command is taken.
// Throughput is one beat per cycle while the consumer keeps up.
// Configuration writes are always taken (o_cfg_ready is tied high) and should only be
// issued while no results are pending. Register indexes: 0 stage count, 1 valve mask,
// 2..7 stage words (bits 7..0 valve pattern, bits 23..8 duration in ms, zero means one).
// On a tick expiry the stage's pattern is applied under the mask, the countdown reloads
// and the stage advances; wrapping past the last stage bumps the cycle number, and the
// next sample reports the finished cycle's statistics with tuser set.
module valve_stage_sequencer_with_stats
    import vss_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // command stream
    input  wire logic                     i_s_tvalid,
    output logic                          o_s_tready,
    input  wire logic [IN_DATA_W-1:0]     i_s_tdata,   // [9:0] oxygen_tenths, [23:10] flow_tenths
    input  wire logic [1:0]               i_s_tuser,   // [1:0] command
    // result stream
    output logic                          o_m_tvalid,
    input  wire logic                     i_m_tready,
    // [7:0] valve_bits, [10:8] stage_index, [42:11] cycle_number, [56:43] oxygen low,
    // [70:57] oxygen high, [102:71] oxygen_sum, [116:103] flow low, [130:117] flow high,
    // [162:131] flow_sum, [178:163] samples in cycle, [183:179] zero
    output logic [OUT_DATA_W-1:0]         o_m_tdata,
    output logic                          o_m_tuser,   // [0] report_valid
    // configuration writes
    input  wire logic                     i_cfg_valid,
    output logic                          o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [WORD_W-1:0]        i_cfg_data
);

    t_cfg                  r_cfg;
    logic                  in_fire;
    t_cmd                  cmd;
    t_seq_view             view;
    t_stat_ctl             ctl;
    t_stats                stats;

    logic                  r_ovalid;
    logic [OUT_DATA_W-1:0] r_odata;
    logic                  r_ouser;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; out-of-list indexes are not possible with 3 bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_stages <= STAGE_W'(MAX_STAGES);
            r_cfg.valve_mask <= '1;
            r_cfg.stage_word <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_STAGE_COUNT) begin
                r_cfg.num_stages <= i_cfg_data[STAGE_W-1:0];
            end
            if (i_cfg_index == CFG_VALVE_MASK) begin
                r_cfg.valve_mask <= i_cfg_data[VALVE_W-1:0];
            end
            for (int i = 0; i < MAX_STAGES; i++) begin
                if (i_cfg_index == CFG_STAGE0 + CFG_IDX_W'(i)) begin
                    r_cfg.stage_word[i] <= i_cfg_data;
                end
            end
        end
    end

    // Take a beat when the output register is free or drains this cycle.
    assign o_s_tready = !r_ovalid || i_m_tready;
    assign in_fire    = i_s_tvalid && o_s_tready;
    assign cmd        = t_cmd'(i_s_tuser);

    vss_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (in_fire),
        .i_cmd   (cmd),
        .i_cfg   (r_cfg),
        .o_view  (view),
        .o_ctl   (ctl)
    );

    vss_stats u_stats (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (ctl),
        .i_oxygen (i_s_tdata[OXY_IN_W-1:0]),
        .i_flow   (i_s_tdata[IN_DATA_W-1:OXY_IN_W]),
        .o_stats  (stats)
    );

    // Output register: load on accept, drop valid once the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (in_fire) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ouser <= ctl.report;
            r_odata <= {5'b0, stats.count, stats.flow_sum, stats.flow_hi, stats.flow_lo,
                        stats.oxy_sum, stats.oxy_hi, stats.oxy_lo,
                        view.cycles, view.stage, view.valves};
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

    // A start resets the reported cycle number and never carries a report.
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && cmd == CMD_START) |=> (o_m_tdata[42:11] == '0 && !o_m_tuser))
        else $error("start beat did not clear cycle number");

    // Stage pointer never leaves the stage table.
    a_stage_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid |-> o_m_tdata[10:8] < STAGE_W'(MAX_STAGES)))
        else $error("stage index out of range");

    // Reports come only from samples.
    a_report_on_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && cmd != CMD_SAMPLE) |=> !o_m_tuser)
        else $error("report on a non-sample command");

    // A result that is not a report carries zero statistics.
    a_quiet_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata[OUT_DATA_W-1:43] == '0))
        else $error("statistics present without report");

endmodule

`default_nettype wire

// ===== test/tb_valve_stage_sequencer_with_stats.sv =====
// Self-checking testbench for valve_stage_sequencer_with_stats: drives command beats and
// register writes, predicts every result beat and compares it field by field.
// Depends on vss_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_valve_stage_sequencer_with_stats
    import vss_pkg::*;
();

    localparam int                QUIET_LIMIT    = 1000;
    localparam int                PHASE_COUNT    = 8;
    localparam int                PHASE_BEATS    = 150;
    localparam logic [13:0]       STATS_LOW_INIT = 14'd9999;
    localparam logic [13:0]       FLOW_CLAMP     = 14'd9999;

    // Result beat as seen on the bus: tuser on top, then tdata from its highest bits down.
    typedef struct packed {
        logic        report;
        logic [4:0]  pad;
        logic [15:0] num_samples;
        logic [31:0] flow_sum;
        logic [13:0] flow_hi;
        logic [13:0] flow_lo;
        logic [31:0] oxy_sum;
        logic [13:0] oxy_hi;
        logic [13:0] oxy_lo;
        logic [31:0] cycle;
        logic [2:0]  stage;
        logic [7:0]  valves;
    } t_status;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_s_tvalid  = 1'b0;
    logic                     o_s_tready;
    logic [IN_DATA_W-1:0]     i_s_tdata   = '0;
    logic [1:0]               i_s_tuser   = '0;
    logic                     o_m_tvalid;
    logic                     i_m_tready  = 1'b1;
    logic [OUT_DATA_W-1:0]    o_m_tdata;
    logic                     o_m_tuser;
    logic                     i_cfg_valid = 1'b0;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [WORD_W-1:0]        i_cfg_data  = '0;

    valve_stage_sequencer_with_stats dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow of the configuration registers, at their reset values.
    // ------------------------------------------------------------------
    logic [2:0]  cfg_count = 3'd6;
    logic [7:0]  cfg_mask  = 8'hFF;
    logic [23:0] cfg_words [MAX_STAGES] = '{default: 24'h0};

    // Shadow of the sequencer and the running cycle statistics.
    logic        seq_running   = 1'b0;
    logic [2:0]  seq_stage     = 3'd0;
    logic [15:0] seq_countdown = 16'd0;
    logic [31:0] seq_cycles    = 32'd0;
    logic        seq_wrapped   = 1'b0;
    logic [7:0]  seq_valves    = 8'h00;
    logic [13:0] oxy_low       = STATS_LOW_INIT;
    logic [13:0] oxy_high      = 14'd0;
    logic [31:0] oxy_total     = 32'd0;
    logic [13:0] flow_low      = STATS_LOW_INIT;
    logic [13:0] flow_high     = 14'd0;
    logic [31:0] flow_total    = 32'd0;
    logic [15:0] samples_seen  = 16'd0;

    t_status expected_status_q[$];

    // Flags that switch off the random gaps on either side for a stretch.
    bit sender_steady   = 1'b0;
    bit receiver_steady = 1'b0;

    int mismatch_count = 0;
    int commands_sent  = 0;
    int register_writes = 0;
    int reports_seen   = 0;
    int results_seen   = 0;
    int quiet_cycles   = 0;
    int stall_left     = 0;

    // Duration of a stage in ticks; a zero field still takes one tick.
    function automatic logic [15:0] stage_ticks(logic [2:0] s);
        logic [15:0] d;
        d = (s < MAX_STAGES) ? cfg_words[s][23:8] : 16'd0;
        return (d == 16'd0) ? 16'd1 : d;
    endfunction

    function automatic void clear_cycle_stats();
        oxy_low      = STATS_LOW_INIT;
        oxy_high     = 14'd0;
        oxy_total    = 32'd0;
        flow_low     = STATS_LOW_INIT;
        flow_high    = 14'd0;
        flow_total   = 32'd0;
        samples_seen = 16'd0;
    endfunction

    function automatic logic [31:0] add_saturated(logic [31:0] a, logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Advance the shadow sequencer by one command and return the result beat it yields.
    function automatic t_status predict_status(t_cmd cmd, logic [9:0] oxy, logic [13:0] flow_in);
        t_status     r;
        logic [13:0] flow;
        logic [13:0] oxy_w;
        logic [2:0]  limit;
        logic [7:0]  pattern;
        r     = '0;
        flow  = (flow_in > FLOW_CLAMP) ? FLOW_CLAMP : flow_in;
        oxy_w = {4'd0, oxy};
        case (cmd)
            CMD_START: begin
                seq_stage     = 3'd0;
                seq_cycles    = 32'd0;
                clear_cycle_stats();
                seq_wrapped   = 1'b0;
                seq_countdown = stage_ticks(3'd0);
                seq_running   = 1'b1;
            end
            CMD_STOP: seq_running = 1'b0;
            CMD_TICK: begin
                if (seq_running) begin
                    if (seq_countdown != 16'd0) seq_countdown--;
                    if (seq_countdown == 16'd0) begin
                        pattern       = (seq_stage < MAX_STAGES)
                                      ? cfg_words[seq_stage][7:0] : 8'h00;
                        seq_valves    = (seq_valves & ~cfg_mask) | (pattern & cfg_mask);
                        seq_countdown = stage_ticks(seq_stage);
                        seq_stage++;
                        // zero acts as one stage, anything above the maximum as the maximum
                        limit = (cfg_count == 3'd0) ? 3'd1 :
                                (cfg_count > MAX_STAGES) ? 3'(MAX_STAGES) : cfg_count;
                        if (seq_stage >= limit) begin
                            seq_stage   = 3'd0;
                            seq_cycles++;
                            seq_wrapped = 1'b1;
                        end
                    end
                end
            end
            default: begin
                if (seq_running) begin
                    // first sample of a new cycle reports the finished one, then folds in
                    if (seq_wrapped) begin
                        r.report      = 1'b1;
                        r.oxy_lo      = oxy_low;
                        r.oxy_hi      = oxy_high;
                        r.oxy_sum     = oxy_total;
                        r.flow_lo     = flow_low;
                        r.flow_hi     = flow_high;
                        r.flow_sum    = flow_total;
                        r.num_samples = samples_seen;
                        clear_cycle_stats();
                        seq_wrapped   = 1'b0;
                    end
                    if (oxy_w < oxy_low)  oxy_low  = oxy_w;
                    if (oxy_w > oxy_high) oxy_high = oxy_w;
                    oxy_total = add_saturated(oxy_total, {22'd0, oxy});
                    if (flow < flow_low)  flow_low  = flow;
                    if (flow > flow_high) flow_high = flow;
                    flow_total = add_saturated(flow_total, {18'd0, flow});
                    if (samples_seen != 16'hFFFF) samples_seen++;
                end
            end
        endcase
        r.valves = seq_valves;
        r.stage  = seq_stage;
        r.cycle  = seq_cycles;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers. Every helper returns right after a rising edge.
    // ------------------------------------------------------------------

    // Send one command beat; hold tvalid high across back-to-back beats.
    task automatic send_command(t_cmd cmd, logic [9:0] oxy = '0, logic [13:0] flow = '0);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 9);
        i_cfg_valid <= 1'b0;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {flow, oxy};
        i_s_tuser  <= cmd;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        expected_status_q.push_back(predict_status(cmd, oxy, flow));
        commands_sent++;
    endtask

    // Drop the command stream and wait until every predicted beat has come back.
    task automatic drain_results();
        i_s_tvalid <= 1'b0;
        while (expected_status_q.size() != 0) @(posedge i_clk);
    endtask

    // Write one register while the block is idle; consecutive writes keep valid high.
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_STAGE_COUNT: cfg_count = data[2:0];
            CFG_VALVE_MASK:  cfg_mask  = data[7:0];
            default:         cfg_words[idx - CFG_STAGE0] = data;
        endcase
        register_writes++;
    endtask

    // ------------------------------------------------------------------
    // Result side: random backpressure, checking, watchdog.
    // ------------------------------------------------------------------

    // After each taken beat, hold tready low for a random number of cycles.
    always @(posedge i_clk) begin
        if (i_m_tready && o_m_tvalid === 1'b1) begin
            stall_left = receiver_steady ? 0 : $urandom_range(0, 9);
            if (stall_left != 0) i_m_tready <= 1'b0;
        end else if (!i_m_tready) begin
            if (stall_left > 1) begin
                stall_left--;
            end else begin
                stall_left = 0;
                i_m_tready <= 1'b1;
            end
        end
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare every taken result beat with the oldest prediction.
    always @(posedge i_clk) begin
        t_status got;
        t_status want;
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            got = {o_m_tuser, o_m_tdata};
            results_seen++;
            if (expected_status_q.size() == 0) begin
                $display("%0t ns: result beat with nothing expected, actual 0x%0h", $time, got);
                mismatch_count++;
            end else begin
                want = expected_status_q.pop_front();
                if (want.report) reports_seen++;
                check_field("report_valid", want.report,      got.report);
                check_field("pad",          want.pad,         got.pad);
                check_field("valve_bits",   want.valves,      got.valves);
                check_field("stage_index",  want.stage,       got.stage);
                check_field("cycle_number", want.cycle,       got.cycle);
                check_field("oxygen low",   want.oxy_lo,      got.oxy_lo);
                check_field("oxygen high",  want.oxy_hi,      got.oxy_hi);
                check_field("oxygen_sum",   want.oxy_sum,     got.oxy_sum);
                check_field("flow low",     want.flow_lo,     got.flow_lo);
                check_field("flow high",    want.flow_hi,     got.flow_hi);
                check_field("flow_sum",     want.flow_sum,    got.flow_sum);
                check_field("samples",      want.num_samples, got.num_samples);
            end
        end
    end

    // End the run when no beat moves on any channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready === 1'b1) ||
            (o_m_tvalid === 1'b1 && i_m_tready) || (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t ns: watchdog, no beat for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, expected_status_q.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Ticks and samples before any start leave everything at reset.
    task automatic test_stopped_commands();
        send_command(CMD_TICK);
        send_command(CMD_SAMPLE, 10'd500, 14'd500);
    endtask

    // Reset registers: six stages of zero duration, so each tick expires a stage.
    // Covers the report of a one-sample cycle and the flow clamp.
    task automatic test_default_cycle();
        send_command(CMD_START);
        send_command(CMD_SAMPLE, 10'h3FF, 14'h3FFF);
        repeat (6) send_command(CMD_TICK);
        send_command(CMD_SAMPLE, 10'd0, 14'd0);
        send_command(CMD_STOP);
        send_command(CMD_TICK);
    endtask

    // Stage count zero and seven, masks of none and all, longest duration, restart.
    task automatic test_stage_count_limits();
        write_register(CFG_STAGE_COUNT, 24'h000000);
        write_register(CFG_VALVE_MASK, 24'h0000AA);
        write_register(CFG_STAGE0, {16'd2, 8'hFF});
        send_command(CMD_START);
        repeat (3) send_command(CMD_TICK);
        send_command(CMD_SAMPLE, 10'd1000, 14'd9999);
        write_register(CFG_STAGE_COUNT, 24'hFFFFFF);
        write_register(CFG_VALVE_MASK, 24'hFFFF00);
        write_register(CFG_STAGE0 + 3'd5, 24'h000155);
        repeat (3) send_command(CMD_TICK);
        write_register(CFG_VALVE_MASK, 24'h0000FF);
        write_register(CFG_STAGE0, 24'hFFFF00);
        send_command(CMD_START);
        send_command(CMD_TICK);
        send_command(CMD_START);
        send_command(CMD_TICK);
        send_command(CMD_STOP);
    endtask

    // Random register settings per phase, then a stream dominated by ticks and samples.
    task automatic test_random_phases();
        int          r;
        int          count_sel;
        int          used;
        bit          restart;
        t_cmd        cmd;
        logic [9:0]  oxy;
        logic [13:0] flow;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            sender_steady   = ($urandom_range(0, 3) == 0);
            receiver_steady = ($urandom_range(0, 3) == 0);
            // phase 0 must restart to leave the long stage of the directed part
            restart   = (p == 0) || ($urandom_range(0, 3) != 0);
            count_sel = (p % 4 == 0) ? 1 : (p % 4 == 1) ? MAX_STAGES : $urandom_range(0, 7);
            used      = (count_sel == 0) ? 1 : (count_sel > MAX_STAGES) ? MAX_STAGES : count_sel;
            write_register(CFG_STAGE_COUNT, {21'($urandom), 3'(count_sel)});
            write_register(CFG_VALVE_MASK, 24'($urandom));
            for (int s = 0; s < MAX_STAGES; s++) begin
                // stages past the count may still be live when the phase keeps running
                if (s < used || !restart)
                    write_register(CFG_STAGE0 + 3'(s), {16'($urandom_range(0, 4)), 8'($urandom)});
                else
                    write_register(CFG_STAGE0 + 3'(s), 24'($urandom));
            end
            if (restart) send_command(CMD_START);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                r    = $urandom_range(0, 99);
                cmd  = (r < 60) ? CMD_TICK : (r < 93) ? CMD_SAMPLE
                     : (r < 97) ? CMD_START : CMD_STOP;
                oxy  = ($urandom_range(0, 9) != 0) ? 10'($urandom_range(0, 1000))
                                                   : 10'($urandom_range(0, 1023));
                flow = ($urandom_range(0, 9) != 0) ? 14'($urandom_range(0, 9999))
                                                   : 14'($urandom_range(0, 16383));
                send_command(cmd, oxy, flow);
            end
        end
        sender_steady   = 1'b0;
        receiver_steady = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_stopped_commands();
        test_default_cycle();
        test_stage_count_limits();
        test_random_phases();
        drain_results();
        // let a late or extra beat show up before judging
        repeat (8) @(posedge i_clk);
        $display("Covered %0d command beats and %0d register writes; checked %0d results,",
                 commands_sent, register_writes, results_seen);
        $display("%0d of them cycle reports, across %0d random phases.", reports_seen, PHASE_COUNT);
        if (mismatch_count == 0 && expected_status_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
